// ----- rtl/sse_pkg.sv -----
package sse_pkg;

  // Byte codes that the parser reacts to.
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;

  // Default depth of the queue between the front and back parts.
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       stream_start;
  } in_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       end_of_event;
  } out_t;

  // Number of results in one queue command (zero-result commands are never queued).
  localparam logic [1:0] CMD_ONE = 2'd1;
  localparam logic [1:0] CMD_TWO = 2'd2;

  // One queue entry: the results that one input byte causes.
  typedef struct packed {
    logic [1:0] cnt;
    out_t       res0;
    out_t       res1;
  } cmd_t;

endpackage

// ----- rtl/sse_front.sv -----
module sse_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          stream_valid,
  output logic          stream_stall,
  input  sse_pkg::in_t  stream_data,
  input  logic          queue_full,
  output logic          push,
  output sse_pkg::cmd_t push_cmd
);

  localparam logic [1:0] MODE_UNDECIDED = 2'd0;
  localparam logic [1:0] MODE_CRLF      = 2'd1;
  localparam logic [1:0] MODE_LF        = 2'd2;

  localparam logic [2:0] PH_START       = 3'd0;
  localparam logic [2:0] PH_NAME_DONE   = 3'd4;
  localparam logic [2:0] PH_AFTER_COLON = 3'd5;
  localparam logic [2:0] PH_CONTENT     = 3'd6;
  localparam logic [2:0] PH_SKIP        = 3'd7;

  typedef struct packed {
    logic [2:0] phase;
    logic       started;
    logic       emit;
    logic [7:0] data;
  } lb_t;

  function automatic logic [7:0] field_char(input logic [1:0] idx);
    logic [7:0] c;
    unique case (idx)
      2'd0:    c = 8'h64;
      2'd1:    c = 8'h61;
      2'd2:    c = 8'h74;
      default: c = 8'h61;
    endcase
    return c;
  endfunction

  // One ordinary byte of a line: walks the field name match, then the content.
  function automatic lb_t line_byte(input logic [2:0] ph, input logic st,
                                    input logic [7:0] b);
    lb_t r;
    r.phase   = ph;
    r.started = st;
    r.emit    = 1'b0;
    r.data    = b;
    if (ph < PH_NAME_DONE) begin
      r.phase = (b == field_char(ph[1:0])) ? ph + 3'd1 : PH_SKIP;
    end else if (ph == PH_NAME_DONE) begin
      if (b == sse_pkg::CH_COLON) begin
        r.emit  = st;
        r.data  = sse_pkg::CH_LF;
        r.phase = PH_AFTER_COLON;
      end else begin
        r.phase = PH_SKIP;
      end
    end else if (ph == PH_AFTER_COLON) begin
      r.phase = PH_CONTENT;
      if (b != sse_pkg::CH_SPACE) begin
        r.emit    = 1'b1;
        r.started = 1'b1;
      end
    end else if (ph == PH_CONTENT) begin
      r.emit    = 1'b1;
      r.started = 1'b1;
    end
    return r;
  endfunction

  logic [1:0] mode, mode_next;
  logic [2:0] phase, phase_next;
  logic       held, held_next;
  logic       started, started_next;

  logic          accept;
  logic [7:0]    b;
  lb_t           lb_held, lb_cur;
  logic [1:0]    cnt;
  sse_pkg::out_t r0, r1;
  logic          done;

  assign b            = stream_data.stream_byte;
  assign stream_stall = queue_full;
  assign accept       = stream_valid && !queue_full;

  always_comb begin
    mode_next    = mode;
    phase_next   = phase;
    held_next    = held;
    started_next = started;
    cnt          = 2'd0;
    r0           = '0;
    r1           = '0;
    done         = 1'b0;
    lb_held      = '0;
    lb_cur       = '0;

    if (stream_data.stream_start) begin
      mode_next    = MODE_UNDECIDED;
      phase_next   = PH_START;
      held_next    = 1'b0;
      started_next = 1'b0;
    end

    // A held CR is resolved first: either it closes a CRLF line ending or it
    // turns out to be an ordinary line byte.
    if (held_next) begin
      held_next = 1'b0;
      if (b == sse_pkg::CH_LF) begin
        if (mode_next == MODE_UNDECIDED) begin
          mode_next = MODE_CRLF;
        end
        if (phase_next == PH_START) begin
          if (started_next) begin
            r0  = '{payload_byte: 8'h00, end_of_event: 1'b1};
            cnt = 2'd1;
          end
          started_next = 1'b0;
        end
        phase_next = PH_START;
        done       = 1'b1;
      end else begin
        lb_held      = line_byte(phase_next, started_next, sse_pkg::CH_CR);
        phase_next   = lb_held.phase;
        started_next = lb_held.started;
        if (lb_held.emit) begin
          r0  = '{payload_byte: lb_held.data, end_of_event: 1'b0};
          cnt = 2'd1;
        end
      end
    end

    if (!done) begin
      if (b == sse_pkg::CH_CR && mode_next != MODE_LF) begin
        held_next = 1'b1;
      end else if (b == sse_pkg::CH_LF &&
                   (mode_next == MODE_UNDECIDED || mode_next == MODE_LF)) begin
        mode_next = MODE_LF;
        if (phase_next == PH_START) begin
          if (started_next) begin
            if (cnt == 2'd0) begin
              r0 = '{payload_byte: 8'h00, end_of_event: 1'b1};
            end else begin
              r1 = '{payload_byte: 8'h00, end_of_event: 1'b1};
            end
            cnt = cnt + 2'd1;
          end
          started_next = 1'b0;
        end
        phase_next = PH_START;
      end else begin
        lb_cur       = line_byte(phase_next, started_next, b);
        phase_next   = lb_cur.phase;
        started_next = lb_cur.started;
        if (lb_cur.emit) begin
          if (cnt == 2'd0) begin
            r0 = '{payload_byte: lb_cur.data, end_of_event: 1'b0};
          end else begin
            r1 = '{payload_byte: lb_cur.data, end_of_event: 1'b0};
          end
          cnt = cnt + 2'd1;
        end
      end
    end
  end

  assign push          = accept && (cnt != 2'd0);
  assign push_cmd.cnt  = cnt;
  assign push_cmd.res0 = r0;
  assign push_cmd.res1 = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_UNDECIDED;
      phase   <= PH_START;
      held    <= 1'b0;
      started <= 1'b0;
    end else if (accept) begin
      mode    <= mode_next;
      phase   <= phase_next;
      held    <= held_next;
      started <= started_next;
    end
  end

endmodule

// ----- rtl/sse_queue.sv -----
module sse_queue #(
  parameter int QueueDepth = sse_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sse_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output sse_pkg::cmd_t head
);

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QueueDepth);

  sse_pkg::cmd_t   entries [QueueDepth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count, count_next;

  assign full      = (count == FullCnt);
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + CntW'(1);
    end else if (pop && !push) begin
      count_next = count - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + PtrW'(1);
      end
      count <= count_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FullCnt)
    else $error("queue count exceeds depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("pop from empty queue");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop))
    else $error("push into full queue");

  a_head_nonzero: assert property (@(posedge clk) disable iff (rst)
    not_empty |-> (head.cnt == sse_pkg::CMD_ONE || head.cnt == sse_pkg::CMD_TWO))
    else $error("queued command carries no result");

endmodule

// ----- rtl/sse_back.sv -----
module sse_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          not_empty,
  input  sse_pkg::cmd_t head,
  output logic          pop,
  output logic          result_valid,
  input  logic          result_stall,
  output sse_pkg::out_t result_data
);

  // sel picks the second result of a two-result command.
  logic sel;
  logic load;

  assign load = not_empty && (!result_valid || !result_stall);
  assign pop  = load && (sel || head.cnt == sse_pkg::CMD_ONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      sel          <= 1'b0;
    end else begin
      if (load) begin
        result_valid <= 1'b1;
        sel          <= !pop;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_data <= sel ? head.res1 : head.res0;
    end
  end

endmodule

// ----- rtl/sse_data_field_extractor.sv -----
// Server-Sent Events data extractor.
// The stream channel (stream_valid, stream_stall, stream_data) takes one raw
// byte of the event stream per transaction, with a flag that clears all parser
// state before that byte is handled. The result channel (result_valid,
// result_stall, result_data) gives the bytes of each event's data lines, a
// newline between consecutive data lines, and a zero byte with end_of_event
// set once the event's blank line arrives. Events without data give nothing.
// A front part tracks the line phase, the separator mode and a held CR, and
// turns each byte into a command of zero, one or two results. Commands go
// through a small queue to a back part that hands results out one per cycle,
// while the receiver does not stall, from an output register. A byte is
// taken every cycle while the queue has room; its earliest result passes
// through a queue entry and then the output register. Bytes that cause two
// results hold the back part for both of them, so a long run of them fills
// the queue and then stalls the stream. When the receiver stalls, the held
// result stays put and the queue absorbs up to QueueDepth further commands
// before stream_stall rises. Reset empties the queue and the output register
// and returns the parser to line start with the separator undecided.
module sse_data_field_extractor #(
  parameter int QueueDepth = sse_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          stream_valid,
  output logic          stream_stall,
  input  sse_pkg::in_t  stream_data,
  output logic          result_valid,
  input  logic          result_stall,
  output sse_pkg::out_t result_data
);

  logic          push, pop, full, not_empty;
  sse_pkg::cmd_t push_cmd, head;

  // Classification of each byte and all parser state.
  sse_front u_front (
    .clk          (clk),
    .rst          (rst),
    .stream_valid (stream_valid),
    .stream_stall (stream_stall),
    .stream_data  (stream_data),
    .queue_full   (full),
    .push         (push),
    .push_cmd     (push_cmd)
  );

  // Decouples the two sides so either may stall on its own.
  sse_queue #(
    .QueueDepth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  // Serializes each command's results into the output register.
  sse_back u_back (
    .clk          (clk),
    .rst          (rst),
    .not_empty    (not_empty),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_data  (result_data)
  );

endmodule
